### src/bfp_pkg.sv
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types and constants for the LSB-first bit field packer.
// ----------------------------------------------------------------------------
package bfp_pkg;

  localparam int MAX_WORD_WIDTH = 64;
  localparam int MAX_ITEM_WIDTH = 32;

  localparam int ITEM_W  = 32;
  localparam int IW_W    = 6;
  localparam int WW_W    = 7;
  localparam int CFG_W   = 7;
  localparam int WORD_W  = 64;
  localparam int COMB_W  = WORD_W + ITEM_W;

  localparam int CMD_DEPTH   = 2;
  localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  localparam logic [0:0] REG_ITEM_WIDTH = 1'd0;
  localparam logic [0:0] REG_WORD_WIDTH = 1'd1;

  localparam logic [IW_W-1:0] ITEM_WIDTH_RESET = 6'd7;
  localparam logic [WW_W-1:0] WORD_WIDTH_RESET = 7'd8;

  typedef struct packed {
    logic [ITEM_W-1:0] item_value;
    logic              last_item;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] packed_word;
    logic [WW_W-1:0]   valid_bits;
    logic              last_word;
  } out_word_t;

  typedef struct packed {
    logic [ITEM_W-1:0] value;
    logic [IW_W-1:0]   iw;
    logic [WW_W-1:0]   ww;
    logic              last;
  } cmd_t;

endpackage

### src/bfp_front.sv
// ----------------------------------------------------------------------------
// bfp_front
// Holds the width registers, masks and classifies each incoming word and
// queues it, with its effective widths, for the packing stage.
// ----------------------------------------------------------------------------
module bfp_front import bfp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             push,
  input  in_word_t         item,
  output logic             full,
  output cmd_t             cmd,
  output logic             cmd_valid,
  input  logic             cmd_take,
  output logic             word_clear
);

  logic [IW_W-1:0]      item_width;
  logic [WW_W-1:0]      word_width;
  cmd_t                 q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;

  logic [WW_W-1:0]   ww_eff;
  logic [IW_W-1:0]   iw_sat;
  logic [IW_W-1:0]   iw_eff;
  logic [ITEM_W-1:0] mask;
  cmd_t              cmd_in;
  logic              accept;

  always_comb begin
    if (word_width == '0) begin
      ww_eff = WW_W'(1);
    end else if (word_width > WW_W'(MAX_WORD_WIDTH)) begin
      ww_eff = WW_W'(MAX_WORD_WIDTH);
    end else begin
      ww_eff = word_width;
    end
    if (item_width > IW_W'(MAX_ITEM_WIDTH)) begin
      iw_sat = IW_W'(MAX_ITEM_WIDTH);
    end else begin
      iw_sat = item_width;
    end
    if ({1'b0, iw_sat} > ww_eff) begin
      iw_eff = ww_eff[IW_W-1:0];
    end else begin
      iw_eff = iw_sat;
    end
    if (iw_eff >= IW_W'(ITEM_W)) begin
      mask = '1;
    end else begin
      mask = (ITEM_W'(1) << iw_eff) - ITEM_W'(1);
    end
    cmd_in.value = item.item_value & mask;
    cmd_in.iw    = iw_eff;
    cmd_in.ww    = ww_eff;
    cmd_in.last  = item.last_item;
  end

  assign full       = (count == CMD_CNT_W'(CMD_DEPTH));
  assign accept     = push && !full;
  assign cmd_valid  = (count != '0);
  assign cmd        = q[rd_ptr];
  assign word_clear = cfg_write && (cfg_index == REG_WORD_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_width <= ITEM_WIDTH_RESET;
      word_width <= WORD_WIDTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ITEM_WIDTH: item_width <= cfg_data[IW_W-1:0];
        REG_WORD_WIDTH: word_width <= cfg_data[WW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + CMD_PTR_W'(1);
      end
      if (cmd_take) begin
        rd_ptr <= rd_ptr + CMD_PTR_W'(1);
      end
      count <= count + CMD_CNT_W'(accept) - CMD_CNT_W'(cmd_take);
    end
  end

endmodule

### src/bfp_back.sv
// ----------------------------------------------------------------------------
// bfp_back
// Packs queued words into output words, flushes on the last word, and
// holds finished words in a small output queue.
// ----------------------------------------------------------------------------
module bfp_back import bfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  logic      cmd_valid,
  output logic      cmd_take,
  input  logic      word_clear,
  output logic      empty,
  input  logic      pop,
  output out_word_t result
);

  logic [WORD_W-1:0]    pend;
  logic [WW_W-1:0]      pc;
  out_word_t            oq [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_CNT_W-1:0] count;

  logic [COMB_W-1:0] comb;
  logic [COMB_W-1:0] rest_wide;
  logic [WW_W:0]     total;
  logic [WW_W:0]     rem;
  logic              closes;
  logic [WORD_W-1:0] wmask;
  logic [WORD_W-1:0] pend_next;
  logic [WW_W-1:0]   pc_next;
  logic              flush;
  out_word_t         r0;
  out_word_t         r1;
  logic              popped;

  always_comb begin
    comb      = {{ITEM_W{1'b0}}, pend} | ({{WORD_W{1'b0}}, cmd.value} << pc);
    total     = {1'b0, pc} + (WW_W + 1)'(cmd.iw);
    closes    = (total >= {1'b0, cmd.ww});
    rem       = total - {1'b0, cmd.ww};
    rest_wide = comb >> cmd.ww;
    if (cmd.ww >= WW_W'(WORD_W)) begin
      wmask = '1;
    end else begin
      wmask = (WORD_W'(1) << cmd.ww) - WORD_W'(1);
    end
    if (closes) begin
      pend_next = rest_wide[WORD_W-1:0];
      pc_next   = rem[WW_W-1:0];
    end else begin
      pend_next = comb[WORD_W-1:0];
      pc_next   = total[WW_W-1:0];
    end
    flush          = cmd.last && (pc_next != '0);
    r0.packed_word = comb[WORD_W-1:0] & wmask;
    r0.valid_bits  = cmd.ww;
    r0.last_word   = cmd.last && (rem == '0);
    r1.packed_word = pend_next;
    r1.valid_bits  = pc_next;
    r1.last_word   = 1'b1;
  end

  assign cmd_take = cmd_valid && (count <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign empty    = (count == '0);
  assign popped   = pop && !empty;
  assign result   = oq[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst || word_clear) begin
      pend <= '0;
      pc   <= '0;
    end else if (cmd_take) begin
      if (cmd.last) begin
        pend <= '0;
        pc   <= '0;
      end else begin
        pend <= pend_next;
        pc   <= pc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      if (closes) begin
        oq[wr_ptr] <= r0;
        if (flush) begin
          oq[wr_ptr + OUT_PTR_W'(1)] <= r1;
        end
      end else if (flush) begin
        oq[wr_ptr] <= r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (cmd_take) begin
        wr_ptr <= wr_ptr + OUT_PTR_W'(closes) + OUT_PTR_W'(flush);
      end
      if (popped) begin
        rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      end
      count <= count + (cmd_take ? (OUT_CNT_W'(closes) + OUT_CNT_W'(flush)) : '0)
               - OUT_CNT_W'(popped);
    end
  end

endmodule

### src/bit_field_packer_core.sv
// ----------------------------------------------------------------------------
// bit_field_packer_core
// Packs narrow words LSB-first into output words of configurable width.
// ----------------------------------------------------------------------------
// One input word is taken every cycle while the downstream side keeps up;
// each input word yields at most two output words (a last word that closes
// a full word and leaves a remainder), and the output queue hands out one
// word per cycle while the consumer pops. A two-entry command queue
// separates classification from packing, and a four-entry output queue
// separates packing from the consumer. Writing word_width drops any
// partially filled word; item_width takes effect on the next input word.
// Write the registers only while the block is idle.
// ----------------------------------------------------------------------------
module bit_field_packer_core import bfp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             push,
  input  in_word_t         item,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output out_word_t        result
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;
  logic word_clear;

  bfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .item       (item),
    .full       (full),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_take   (cmd_take),
    .word_clear (word_clear)
  );

  bfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_take   (cmd_take),
    .word_clear (word_clear),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

### verif/bit_field_packer_core_tb.sv
// ----------------------------------------------------------------------------
// bit_field_packer_core_tb
// Self-checking bench for the LSB-first bit field packer. A queue-fed driver
// pushes items and a monitor pops packed words at random rates. Every word
// that the block returns is checked against a bit-accurate packing model
// kept in the bench. The run covers many item and word width settings,
// including zero, clamped and saturated widths.
// ----------------------------------------------------------------------------
module bit_field_packer_core_tb;
  import bfp_pkg::*;

  localparam int NUM_SETTINGS = 16;
  localparam int ITEMS_PER_SETTING = 80;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [0:0]       cfg_index = REG_ITEM_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             push = 1'b0;
  in_word_t         item = '0;
  logic             full;
  logic             empty;
  logic             pop = 1'b0;
  out_word_t        result;

  in_word_t  items_to_send[$];
  out_word_t packed_words_due[$];

  logic [IW_W-1:0] cur_item_width = ITEM_WIDTH_RESET;
  logic [WW_W-1:0] cur_word_width = WORD_WIDTH_RESET;
  logic [63:0]     pend_bits = '0;
  int              pend_count = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;

  bit_field_packer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  always #6 clk = ~clk;

  function automatic logic [63:0] low_bits(input int n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  task automatic pack_item(input in_word_t w);
    int          ww;
    int          iw;
    int          total;
    int          rem;
    logic [127:0] acc;
    logic [127:0] upper;
    logic [63:0] v;
    out_word_t   r;
    ww = (cur_word_width == 0) ? 1 : int'(cur_word_width);
    if (ww > MAX_WORD_WIDTH) ww = MAX_WORD_WIDTH;
    iw = (cur_item_width > MAX_ITEM_WIDTH) ? MAX_ITEM_WIDTH : int'(cur_item_width);
    if (iw > ww) iw = ww;
    v = {32'd0, w.item_value} & low_bits(iw);
    acc = {64'd0, v};
    acc = acc << pend_count;
    acc = acc | {64'd0, pend_bits};
    total = pend_count + iw;
    if (total >= ww) begin
      rem = total - ww;
      r.packed_word = acc[63:0] & low_bits(ww);
      r.valid_bits = ww[WW_W-1:0];
      r.last_word = w.last_item && (rem == 0);
      packed_words_due.push_back(r);
      upper = acc >> ww;
      pend_bits = upper[63:0] & low_bits(rem);
      pend_count = rem;
    end else begin
      pend_bits = acc[63:0];
      pend_count = total;
    end
    if (w.last_item) begin
      if (pend_count > 0) begin
        r.packed_word = pend_bits & low_bits(pend_count);
        r.valid_bits = pend_count[WW_W-1:0];
        r.last_word = 1'b1;
        packed_words_due.push_back(r);
      end
      pend_bits = '0;
      pend_count = 0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        pack_item(item);
        void'(items_to_send.pop_front());
      end
      if (items_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        push <= 1'b1;
        item <= items_to_send[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t due;
    if (!rst && pop && !empty) begin
      if (packed_words_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word %h", $time, result);
      end else begin
        due = packed_words_due.pop_front();
        if (result.packed_word !== due.packed_word) begin
          mismatch_count++;
          $display("%0t: packed_word expected %h actual %h", $time, due.packed_word,
                   result.packed_word);
        end
        if (result.valid_bits !== due.valid_bits) begin
          mismatch_count++;
          $display("%0t: valid_bits expected %0d actual %0d", $time, due.valid_bits,
                   result.valid_bits);
        end
        if (result.last_word !== due.last_word) begin
          mismatch_count++;
          $display("%0t: last_word expected %b actual %b", $time, due.last_word,
                   result.last_word);
        end
      end
    end
    pop <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("bit_field_packer_core_tb NOT OK");
    $finish;
  end

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_ITEM_WIDTH) begin
      cur_item_width = data[IW_W-1:0];
    end else begin
      cur_word_width = data;
      pend_bits = '0;
      pend_count = 0;
    end
  endtask

  task automatic wait_idle();
    while (!(items_to_send.size() == 0 && !push && packed_words_due.size() == 0))
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input int ph);
    case (ph)
      0: begin write_reg(REG_ITEM_WIDTH, 7'd0);  write_reg(REG_WORD_WIDTH, 7'd5);   end
      1: begin write_reg(REG_ITEM_WIDTH, 7'h7F); write_reg(REG_WORD_WIDTH, 7'd127); end
      2: begin write_reg(REG_ITEM_WIDTH, 7'd32); write_reg(REG_WORD_WIDTH, 7'd64);  end
      3: begin write_reg(REG_ITEM_WIDTH, 7'd1);  write_reg(REG_WORD_WIDTH, 7'd1);   end
      4: begin write_reg(REG_ITEM_WIDTH, 7'd40); write_reg(REG_WORD_WIDTH, 7'd0);   end
      5: begin write_reg(REG_ITEM_WIDTH, 7'd13); write_reg(REG_WORD_WIDTH, 7'd64);  end
      6: write_reg(REG_ITEM_WIDTH, 7'd3);
      7: begin write_reg(REG_ITEM_WIDTH, 7'd5);  write_reg(REG_WORD_WIDTH, 7'd3);   end
      8: begin write_reg(REG_ITEM_WIDTH, 7'd17); write_reg(REG_WORD_WIDTH, 7'd20);  end
      9: begin write_reg(REG_ITEM_WIDTH, 7'd32); write_reg(REG_WORD_WIDTH, 7'd33);  end
      10: write_reg(REG_ITEM_WIDTH, 7'd31);
      11: begin write_reg(REG_ITEM_WIDTH, 7'd1); write_reg(REG_WORD_WIDTH, 7'd64);  end
      15: write_reg(REG_ITEM_WIDTH, CFG_W'($urandom_range(0, 63)));
      default: begin
        write_reg(REG_ITEM_WIDTH, CFG_W'($urandom_range(0, 63)));
        write_reg(REG_WORD_WIDTH, CFG_W'($urandom_range(0, 127)));
      end
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic in_word_t make_item(input logic [31:0] v, input logic l);
    in_word_t w;
    w.item_value = v;
    w.last_item = l;
    return w;
  endfunction

  initial begin
    int          ph;
    int          n;
    logic [31:0] v;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 87;
    @(negedge clk);
    items_to_send.push_back(make_item(32'h0000_0000, 1'b0));
    items_to_send.push_back(make_item(32'hFFFF_FFFF, 1'b0));
    items_to_send.push_back(make_item(32'hAAAA_AAAA, 1'b0));
    items_to_send.push_back(make_item(32'h5555_5555, 1'b0));
    items_to_send.push_back(make_item(32'h0000_007F, 1'b0));
    items_to_send.push_back(make_item(32'h0000_0080, 1'b1));
    items_to_send.push_back(make_item(32'h0000_0000, 1'b1));
    items_to_send.push_back(make_item(32'hFFFF_FFFF, 1'b1));
    for (n = 0; n < 8; n++) items_to_send.push_back(make_item(32'hFFFF_FF80 | n, 1'b0));
    items_to_send.push_back(make_item(32'h0000_0001, 1'b1));
    items_to_send.push_back(make_item(32'h8000_0000, 1'b0));
    items_to_send.push_back(make_item(32'h7FFF_FFFF, 1'b1));
    for (ph = 0; ph < NUM_SETTINGS; ph++) begin
      wait_idle();
      apply_setting(ph);
      @(negedge clk);
      case (ph * 3 / NUM_SETTINGS)
        0: begin send_idle_pct = 27; recv_idle_pct = 87; end
        1: begin send_idle_pct = 87; recv_idle_pct = 27; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (n = 0; n < ITEMS_PER_SETTING; n++) begin
        case ($urandom_range(0, 3))
          0: v = $urandom_range(0, 15);
          1: v = $urandom | 32'hFFFF_0000;
          default: v = $urandom;
        endcase
        items_to_send.push_back(make_item(v, $urandom_range(0, 9) == 0));
      end
    end
    wait_idle();
    if (mismatch_count == 0 && packed_words_due.size() == 0)
      $display("bit_field_packer_core_tb OK");
    else
      $display("bit_field_packer_core_tb NOT OK");
    $finish;
  end

endmodule

### sim.f
src/bfp_pkg.sv
src/bfp_front.sv
src/bfp_back.sv
src/bit_field_packer_core.sv
verif/bit_field_packer_core_tb.sv
